// ===== design/sptt_pkg.sv =====
`timescale 1ns / 1ps

package sptt_pkg;

    localparam int DEF_MAX_SECTIONS = 16;

    localparam logic [9:0] MAX_TPB = 10'd960;

    // divider: dividend and divisor widths
    localparam int DVW = 52;
    localparam int DSW = 33;
    localparam logic [DVW-1:0] PERIOD_NUM = 52'd245760000000;
    localparam logic [35:0] ACC_MAX = 36'hF_FFFF_FFFF;

    localparam logic [2:0] CMD_ADVANCE   = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_RESET_POS = 3'd3;
    localparam logic [2:0] CMD_SET_POS   = 3'd4;
    localparam logic [2:0] CMD_LOAD      = 3'd5;

    localparam logic [1:0] REG_TPB    = 2'd0;
    localparam logic [1:0] REG_TEMPO  = 2'd1;
    localparam logic [1:0] REG_BEATS  = 2'd2;
    localparam logic [1:0] REG_COUNT  = 2'd3;

    localparam logic [15:0] RST_TEMPO = 16'd1920;
    localparam logic [9:0]  RST_TPB   = 10'd24;
    localparam logic [5:0]  RST_BEATS = 6'd4;

    typedef enum logic [1:0] {
        PH_CFG,
        PH_LOC,
        PH_ADV,
        PH_RAMP
    } t_phase;

    function automatic logic [15:0] sat_tempo(input logic [15:0] t);
        return (t < 16'd16) ? 16'd16 : t;
    endfunction

    function automatic logic [5:0] fix_beats(input logic [5:0] b);
        return (b == 6'd0) ? 6'd1 : b;
    endfunction

endpackage

// ===== design/song_position_tick_timer.sv =====
`timescale 1ns / 1ps

// Song position tick timer.
// Input stream: s_axis_tuser carries the command, s_axis_tdata the operands.
// Output stream: one result beat per input beat, in order.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_wdata, written while idle.
// One item at a time. Stop, reset position, load, unknown commands and an
// advance while stopped go straight to the result; a running advance adds
// its time to the accumulator and compares it with the period, and a tick
// steps the position and may check the section table when the measure rolls.
// Each tempo change runs the shared bit-serial divider to get the tick
// period; a ramp step runs it twice (ramp quotient, then period). Start,
// and set position while running, walk the section table entry by entry
// (registered read), then apply the section found with one period division.
// After reset, and after a write of register 0 or 1, the period is
// recomputed; no item is accepted meanwhile.
// Reset puts the position at 1/1/0, stopped, tempo 1920; the section table
// holds nothing until loaded.
// A result waits in the output register while m_axis_tready is low; the
// next item may be accepted meanwhile but its result waits until the
// register is free.
module song_position_tick_timer
    import sptt_pkg::*;
#(
    parameter int MAX_SECTIONS = DEF_MAX_SECTIONS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // elapsed_us, pos_measure, pos_beat, pos_tick, entry_index,
    // entry_first_measure, entry_last_measure, entry_tempo,
    // entry_target_tempo, entry_beats
    input  logic [119:0] s_axis_tdata,
    // cmd
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tick_fired, measure_now, beat_now, tick_now, section_now,
    // section_changed, song_ended, running_now, tempo_now
    output logic [55:0]  m_axis_tdata
);

    localparam int SW  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int NW  = $clog2(MAX_SECTIONS + 1);
    localparam int DCW = $clog2(DVW + 1);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOC_START,
        ST_LOC_WAIT,
        ST_LOC_CHK,
        ST_AP_WAIT,
        ST_AP0,
        ST_AP1,
        ST_AP2,
        ST_PMUL,
        ST_DIV,
        ST_DIV_END,
        ST_ADV_ADD,
        ST_ADV_CMP,
        ST_ADV_ROLL,
        ST_ADV_WAIT,
        ST_ADV_CHK,
        ST_RCHK,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_R4,
        ST_R5,
        ST_R6,
        ST_DONE
    } t_state;

    t_state r_state;
    t_phase r_phase;

    // input fields
    logic [2:0]  in_cmd;
    logic [15:0] in_us;
    logic [15:0] in_meas;
    logic [5:0]  in_beat;
    logic [9:0]  in_tick;
    logic [3:0]  in_idx;
    logic [14:0] in_first;
    logic [14:0] in_last;
    logic [15:0] in_tempo;
    logic [15:0] in_target;
    logic [5:0]  in_beats;

    assign in_cmd    = s_axis_tuser;
    assign in_us     = s_axis_tdata[15:0];
    assign in_meas   = s_axis_tdata[31:16];
    assign in_beat   = s_axis_tdata[37:32];
    assign in_tick   = s_axis_tdata[47:38];
    assign in_idx    = s_axis_tdata[51:48];
    assign in_first  = s_axis_tdata[66:52];
    assign in_last   = s_axis_tdata[81:67];
    assign in_tempo  = s_axis_tdata[97:82];
    assign in_target = s_axis_tdata[113:98];
    assign in_beats  = s_axis_tdata[119:114];

    // configuration and state
    logic [9:0]  r_tpb;
    logic [4:0]  r_cnt;
    logic [15:0] r_meas;
    logic [5:0]  r_beat;
    logic [9:0]  r_tick;
    logic [SW-1:0] r_sec;
    logic        r_run;
    logic [35:0] r_acc;
    logic [33:0] r_period;
    logic [15:0] r_tempo;
    logic [5:0]  r_mb;
    logic        r_ramp;
    logic signed [32:0] r_x0;
    logic signed [32:0] r_x1;
    logic [15:0] r_rfrom;
    logic [15:0] r_rto;
    logic        r_per_pend;

    // item work registers
    logic        r_fired;
    logic        r_chg;
    logic        r_end;
    logic [15:0] r_us;
    logic [SW-1:0] r_idx;
    logic [SW-1:0] r_fidx;
    logic        r_found;
    logic        r_nxt;
    logic        r_roll;
    logic signed [22:0] r_ma;
    logic [20:0] r_mb2;
    logic signed [23:0] r_p1;
    logic signed [35:0] r_p2;
    logic signed [35:0] r_xd;
    logic signed [35:0] r_den;
    logic [34:0] r_xm;
    logic [15:0] r_ddm;
    logic        r_neg;
    logic [DVW-1:0] r_prod;

    // divider
    logic [DVW-1:0] r_dvd;
    logic [DSW-1:0] r_dvsr;
    logic [DSW-1:0] r_rem;
    logic [DCW-1:0] r_dcnt;
    logic           r_div_ramp;

    logic        r_ovalid;
    logic [55:0] r_odata;

    // section table
    logic [29:0] mem_bnd [MAX_SECTIONS];
    logic [37:0] mem_tmp [MAX_SECTIONS];
    logic [29:0] r_bnd_q;
    logic [37:0] r_tmp_q;

    logic s_acc;
    logic m_free;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_per_pend;
    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_free = !r_ovalid || m_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (s_acc && (in_cmd == CMD_LOAD) && (32'(in_idx) < MAX_SECTIONS)) begin
            mem_bnd[SW'(in_idx)] <= {in_last, in_first};
            mem_tmp[SW'(in_idx)] <= {in_beats, in_target, in_tempo};
        end
        r_bnd_q <= mem_bnd[r_idx];
        r_tmp_q <= mem_tmp[r_idx];
    end

    // derived values
    logic [9:0]    tpb_eff;
    logic [NW-1:0] n_eff;
    assign tpb_eff = (r_tpb == 10'd0) ? 10'd1 : ((r_tpb > MAX_TPB) ? MAX_TPB : r_tpb);
    assign n_eff   = (32'(r_cnt) > MAX_SECTIONS) ? NW'(MAX_SECTIONS) : NW'(r_cnt);

    logic [14:0] q_first;
    logic [14:0] q_last;
    logic [15:0] q_t0;
    logic [15:0] q_t1;
    logic [5:0]  q_bt;
    assign q_first = r_bnd_q[14:0];
    assign q_last  = r_bnd_q[29:15];
    assign q_t0    = sat_tempo(r_tmp_q[15:0]);
    assign q_t1    = sat_tempo(r_tmp_q[31:16]);
    assign q_bt    = fix_beats(r_tmp_q[37:32]);

    logic signed [16:0] meas_s;
    logic signed [16:0] first_s;
    logic signed [16:0] last_s;
    logic               hit;
    assign meas_s  = $signed({r_meas[15], r_meas});
    assign first_s = $signed({2'b00, q_first});
    assign last_s  = $signed({2'b00, q_last});
    assign hit     = (meas_s >= first_s) && (meas_s <= last_s);

    // advance
    logic [36:0] acc_sum;
    logic [10:0] tick_inc;
    logic        roll_t;
    logic [6:0]  beat_inc;
    logic        roll_b;
    assign acc_sum  = {1'b0, r_acc} + {13'd0, r_us, 8'd0};
    assign tick_inc = {1'b0, r_tick} + 11'd1;
    assign roll_t   = tick_inc >= {1'b0, tpb_eff};
    assign beat_inc = roll_t ? ({1'b0, r_beat} + 7'd1) : {1'b0, r_beat};
    assign roll_b   = beat_inc > {1'b0, r_mb};

    // ramp line end points
    logic signed [15:0] fm1;
    logic signed [22:0] ma_c;
    logic [20:0]        mb2_c;
    logic signed [33:0] x0_c;
    logic [30:0]        x1_c;
    assign fm1   = $signed({1'b0, q_first}) - 16'sd1;
    assign ma_c  = fm1 * $signed({1'b0, r_mb});
    assign mb2_c = q_last * r_mb;
    assign x0_c  = r_ma * $signed({1'b0, tpb_eff});
    assign x1_c  = r_mb2 * tpb_eff;

    // ramp position
    logic signed [16:0] m_m1;
    logic signed [23:0] p1_c;
    logic signed [24:0] bsum;
    logic signed [35:0] p2_c;
    logic signed [35:0] xd_c;
    logic signed [35:0] den_c;
    logic signed [16:0] dd_c;
    logic [35:0]        xd_abs;
    logic [35:0]        den_abs;
    logic [16:0]        dd_abs;
    logic [33:0]        prod_lo;
    logic [32:0]        prod_hi;
    assign m_m1    = meas_s - 17'sd1;
    assign p1_c    = m_m1 * $signed({1'b0, r_mb});
    assign bsum    = 25'(r_p1) + $signed({19'd0, r_beat}) - 25'sd1;
    assign p2_c    = bsum * $signed({1'b0, tpb_eff});
    assign xd_c    = r_p2 + $signed({26'd0, r_tick}) - 36'(r_x0);
    assign den_c   = 36'(r_x1) - 36'(r_x0);
    assign dd_c    = $signed({1'b0, r_rto}) - $signed({1'b0, r_rfrom});
    assign xd_abs  = r_xd[35] ? 36'(-r_xd) : 36'(r_xd);
    assign den_abs = r_den[35] ? 36'(-r_den) : 36'(r_den);
    assign dd_abs  = dd_c[16] ? 17'(-dd_c) : 17'(dd_c);
    assign prod_lo = r_ddm * r_xm[17:0];
    assign prod_hi = r_ddm * r_xm[34:18];

    // divider step
    logic [DSW:0] rem_sh;
    logic         take;
    logic [DSW:0] rem_nx;
    assign rem_sh = {r_rem, r_dvd[DVW-1]};
    assign take   = rem_sh >= {1'b0, r_dvsr};
    assign rem_nx = take ? (rem_sh - {1'b0, r_dvsr}) : rem_sh;

    // ramp tempo from quotient
    logic               rem_nz;
    logic signed [53:0] qs;
    logic signed [53:0] t_c;
    logic [15:0]        t_sat;
    assign rem_nz = r_rem != '0;
    assign qs     = r_neg ? (-$signed({2'b00, r_dvd}) - $signed({53'd0, rem_nz}))
                          : $signed({2'b00, r_dvd});
    assign t_c    = qs + $signed({38'd0, r_rfrom});
    assign t_sat  = (t_c < 54'sd16) ? 16'd16 :
                    ((t_c > 54'sd65535) ? 16'hFFFF : t_c[15:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_CFG;
            r_tpb      <= RST_TPB;
            r_cnt      <= 5'd0;
            r_meas     <= 16'd1;
            r_beat     <= 6'd1;
            r_tick     <= 10'd0;
            r_sec      <= '0;
            r_run      <= 1'b0;
            r_acc      <= 36'd0;
            r_tempo    <= RST_TEMPO;
            r_mb       <= RST_BEATS;
            r_ramp     <= 1'b0;
            r_x0       <= '0;
            r_x1       <= '0;
            r_per_pend <= 1'b1;
            r_ovalid   <= 1'b0;
            r_idx      <= '0;
            r_dcnt     <= '0;
            r_div_ramp <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (r_per_pend) begin
                        r_per_pend <= 1'b0;
                        r_phase    <= PH_CFG;
                        r_state    <= ST_PMUL;
                    end else if (s_acc) begin
                        r_fired <= 1'b0;
                        r_chg   <= 1'b0;
                        r_end   <= 1'b0;
                        r_us    <= in_us;
                        r_state <= ST_DONE;
                        case (in_cmd)
                            CMD_ADVANCE: begin
                                if (r_run) begin
                                    r_state <= ST_ADV_ADD;
                                end
                            end
                            CMD_START: begin
                                r_fired <= 1'b1;
                                r_run   <= 1'b1;
                                r_acc   <= 36'd0;
                                r_phase <= PH_LOC;
                                r_state <= ST_LOC_START;
                            end
                            CMD_STOP: begin
                                r_run <= 1'b0;
                            end
                            CMD_RESET_POS: begin
                                r_run  <= 1'b0;
                                r_meas <= 16'd1;
                                r_beat <= 6'd1;
                                r_tick <= 10'd0;
                                r_acc  <= 36'd0;
                            end
                            CMD_SET_POS: begin
                                r_meas <= in_meas;
                                r_beat <= in_beat;
                                r_tick <= in_tick;
                                if (r_run) begin
                                    r_phase <= PH_LOC;
                                    r_state <= ST_LOC_START;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_LOC_START: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    if (n_eff == '0) begin
                        r_state <= ST_DONE;
                    end else if (meas_s <= 17'sd1) begin
                        r_state <= ST_AP_WAIT;
                    end else begin
                        r_state <= ST_LOC_WAIT;
                    end
                end

                ST_LOC_WAIT: begin
                    r_state <= ST_LOC_CHK;
                end

                ST_LOC_CHK: begin
                    if (hit) begin
                        r_fidx  <= r_idx;
                        r_found <= 1'b1;
                    end
                    if (32'(r_idx) + 32'd1 < 32'(n_eff)) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_LOC_WAIT;
                    end else if (hit) begin
                        r_state <= ST_AP0;
                    end else if (r_found) begin
                        r_idx   <= r_fidx;
                        r_state <= ST_AP_WAIT;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end

                ST_AP_WAIT: begin
                    r_state <= ST_AP0;
                end

                ST_AP0: begin
                    r_sec   <= r_idx;
                    r_tempo <= q_t0;
                    r_mb    <= q_bt;
                    r_chg   <= 1'b1;
                    r_ramp  <= q_t0 != q_t1;
                    r_rfrom <= q_t0;
                    r_rto   <= q_t1;
                    r_state <= (q_t0 != q_t1) ? ST_AP1 : ST_PMUL;
                end

                ST_AP1: begin
                    r_ma    <= ma_c;
                    r_mb2   <= mb2_c;
                    r_state <= ST_AP2;
                end

                ST_AP2: begin
                    r_x0    <= x0_c[32:0];
                    r_x1    <= $signed({2'b00, x1_c});
                    r_state <= ST_PMUL;
                end

                ST_PMUL: begin
                    r_dvsr     <= DSW'(r_tempo * tpb_eff);
                    r_dvd      <= PERIOD_NUM;
                    r_rem      <= '0;
                    r_dcnt     <= DCW'(DVW);
                    r_div_ramp <= 1'b0;
                    r_state    <= ST_DIV;
                end

                ST_DIV: begin
                    r_rem  <= rem_nx[DSW-1:0];
                    r_dvd  <= {r_dvd[DVW-2:0], take};
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == DCW'(1)) begin
                        r_state <= ST_DIV_END;
                    end
                end

                ST_DIV_END: begin
                    if (r_div_ramp) begin
                        r_tempo <= t_sat;
                        r_state <= ST_PMUL;
                    end else begin
                        r_period <= r_dvd[33:0];
                        unique case (r_phase)
                            PH_CFG:  r_state <= ST_IDLE;
                            PH_ADV:  r_state <= ST_RCHK;
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end

                ST_ADV_ADD: begin
                    r_acc   <= acc_sum[36] ? ACC_MAX : acc_sum[35:0];
                    r_state <= ST_ADV_CMP;
                end

                ST_ADV_CMP: begin
                    if (r_acc < {2'b00, r_period}) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_acc   <= r_acc - {2'b00, r_period};
                        r_fired <= 1'b1;
                        r_tick  <= roll_t ? 10'd0 : tick_inc[9:0];
                        r_beat  <= roll_b ? 6'd1 : beat_inc[5:0];
                        r_roll  <= roll_b;
                        r_state <= ST_ADV_ROLL;
                    end
                end

                ST_ADV_ROLL: begin
                    r_phase <= PH_ADV;
                    if (!r_roll) begin
                        r_state <= ST_RCHK;
                    end else begin
                        if ($signed(r_meas) < 16'sd32767) begin
                            r_meas <= r_meas + 16'd1;
                        end
                        if (32'(n_eff) > 32'(r_sec) + 32'd1) begin
                            r_idx   <= r_sec + 1'b1;
                            r_nxt   <= 1'b1;
                            r_state <= ST_ADV_WAIT;
                        end else if (32'(n_eff) == 32'(r_sec) + 32'd1) begin
                            r_idx   <= r_sec;
                            r_nxt   <= 1'b0;
                            r_state <= ST_ADV_WAIT;
                        end else begin
                            r_state <= ST_RCHK;
                        end
                    end
                end

                ST_ADV_WAIT: begin
                    r_state <= ST_ADV_CHK;
                end

                ST_ADV_CHK: begin
                    r_state <= ST_RCHK;
                    if (r_nxt) begin
                        if (meas_s == first_s) begin
                            r_state <= ST_AP0;
                        end
                    end else if (meas_s > last_s) begin
                        r_end <= 1'b1;
                        r_run <= 1'b0;
                    end
                end

                ST_RCHK: begin
                    r_phase <= PH_RAMP;
                    r_state <= (r_ramp && (r_x1 != r_x0)) ? ST_R1 : ST_DONE;
                end

                ST_R1: begin
                    r_p1    <= p1_c;
                    r_state <= ST_R2;
                end

                ST_R2: begin
                    r_p2    <= p2_c;
                    r_state <= ST_R3;
                end

                ST_R3: begin
                    r_xd    <= xd_c;
                    r_den   <= den_c;
                    r_state <= ST_R4;
                end

                ST_R4: begin
                    r_xm    <= xd_abs[34:0];
                    r_ddm   <= dd_abs[15:0];
                    r_dvsr  <= den_abs[DSW-1:0];
                    r_neg   <= dd_c[16] ^ r_xd[35] ^ r_den[35];
                    r_state <= ST_R5;
                end

                ST_R5: begin
                    r_prod  <= DVW'(prod_lo);
                    r_state <= ST_R6;
                end

                ST_R6: begin
                    r_dvd      <= r_prod + (DVW'(prod_hi) << 18);
                    r_rem      <= '0;
                    r_dcnt     <= DCW'(DVW);
                    r_div_ramp <= 1'b1;
                    r_state    <= ST_DIV;
                end

                ST_DONE: begin
                    if (m_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_tempo, r_run, r_end, r_chg, 4'(r_sec),
                                     r_tick, r_beat, r_meas, r_fired};
                        r_state  <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TPB: begin
                        r_tpb      <= i_cfg_wdata[9:0];
                        r_per_pend <= 1'b1;
                    end
                    REG_TEMPO: begin
                        r_tempo    <= sat_tempo(i_cfg_wdata);
                        r_per_pend <= 1'b1;
                    end
                    REG_BEATS: r_mb  <= fix_beats(i_cfg_wdata[5:0]);
                    REG_COUNT: r_cnt <= i_cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("item accepted while busy");

    a_tempo_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tempo >= 16'd16)
        else $error("tempo below floor");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DONE))
        else $error("result beat without finished item");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dcnt != '0))
        else $error("divider count underflow");

endmodule

// ===== sim/tb_song_position_tick_timer.sv =====
`timescale 1ns / 1ps

module tb_song_position_tick_timer;
    import sptt_pkg::*;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         RX_LONG_HOLD = 400;

    typedef struct packed {
        logic [5:0]  beats;
        logic [15:0] target;
        logic [15:0] tempo;
        logic [14:0] last;
        logic [14:0] first;
        logic [3:0]  index;
        logic [9:0]  tick;
        logic [5:0]  beat;
        logic [15:0] measure;
        logic [15:0] elapsed;
    } cmd_data_t;

    typedef struct {
        logic [2:0] cmd;
        cmd_data_t  d;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] tempo;
        logic        running;
        logic        ended;
        logic        changed;
        logic [3:0]  section;
        logic [9:0]  tick;
        logic [5:0]  beat;
        logic [15:0] measure;
        logic        fired;
    } position_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;

    song_position_tick_timer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // timer model state
    logic [9:0]  cfg_tpb;
    logic [15:0] cfg_tempo0;
    logic [5:0]  cfg_beats0;
    logic [4:0]  cfg_count;
    int          pm_measure, pm_beat, pm_tick, pm_section, pm_tempo, pm_beats;
    bit          pm_running, pm_ramp, pm_changed, pm_ended;
    longint      pm_accum, pm_period, pm_x0, pm_x1;
    int          pm_from, pm_to;
    logic [29:0] sect_bounds [16];
    logic [37:0] sect_tempi [16];

    cmd_item_t   pending_cmds [$];
    position_t   expected_pos [$];
    cmd_item_t   cur_cmd;
    int          tx_gap, rx_wait, rx_long_cnt, idle_cycles, errors;
    bit          tx_got, rx_got, rx_long_req, no_idle;

    function automatic int tpb_used();
        if (cfg_tpb < 1) return 1;
        if (cfg_tpb > 960) return 960;
        return int'(cfg_tpb);
    endfunction

    function automatic int clamp_tempo(longint t);
        if (t < 16) return 16;
        if (t > 65535) return 65535;
        return int'(t);
    endfunction

    function automatic longint tick_index(longint m, longint b, longint t, longint bts);
        return ((m - 1) * bts + (b - 1)) * tpb_used() + t;
    endfunction

    function automatic int sect_first(int i);
        return int'(sect_bounds[i][14:0]);
    endfunction

    function automatic int sect_last(int i);
        return int'(sect_bounds[i][29:15]);
    endfunction

    function automatic int count_used();
        return (cfg_count > 16) ? 16 : int'(cfg_count);
    endfunction

    task automatic load_tempo(int t);
        pm_tempo  = clamp_tempo(t);
        pm_period = 64'd245760000000 / (longint'(pm_tempo) * tpb_used());
    endtask

    task automatic enter_section(int i);
        logic [37:0] e;
        int          t0, t1, bt;
        e  = sect_tempi[i];
        t0 = clamp_tempo(e[15:0]);
        t1 = clamp_tempo(e[31:16]);
        bt = (e[37:32] == 0) ? 1 : int'(e[37:32]);
        pm_section = i;
        load_tempo(t0);
        pm_beats   = bt;
        pm_changed = 1'b1;
        pm_ramp    = (t0 != t1);
        if (pm_ramp) begin
            pm_x0   = tick_index(sect_first(i), 1, 0, bt);
            pm_x1   = tick_index(sect_last(i) + 1, 1, 0, bt);
            pm_from = t0;
            pm_to   = t1;
        end
    endtask

    task automatic find_section();
        int n;
        n = count_used();
        if (n == 0) return;
        if (pm_measure <= 1) begin
            enter_section(0);
            return;
        end
        for (int i = 0; i < n; i++)
            if (pm_measure >= sect_first(i) && pm_measure <= sect_last(i))
                enter_section(i);
    endtask

    task automatic advance_time(int us, output bit fired);
        int     n;
        longint x, num, den, q;
        fired = 1'b0;
        if (!pm_running) return;
        pm_accum += longint'(us) * 256;
        if (pm_accum > 64'hF_FFFF_FFFF) pm_accum = 64'hF_FFFF_FFFF;
        if (pm_accum < pm_period) return;
        pm_accum -= pm_period;
        fired = 1'b1;
        pm_tick++;
        if (pm_tick >= tpb_used()) begin
            pm_tick = 0;
            pm_beat++;
        end
        if (pm_beat > pm_beats) begin
            pm_beat = 1;
            if (pm_measure < 32767) pm_measure++;
            n = count_used();
            if (n > pm_section + 1 && pm_measure == sect_first(pm_section + 1)) begin
                enter_section(pm_section + 1);
            end else if (n == pm_section + 1 && pm_measure > sect_last(pm_section)) begin
                pm_ended   = 1'b1;
                pm_running = 1'b0;
            end
        end
        if (pm_ramp && pm_x1 != pm_x0) begin
            x   = tick_index(pm_measure, pm_beat, pm_tick, pm_beats);
            num = longint'(pm_to - pm_from) * (x - pm_x0);
            den = pm_x1 - pm_x0;
            if (den < 0) begin
                den = -den;
                num = -num;
            end
            q = num / den;
            if (num % den != 0 && num < 0) q--;
            load_tempo(clamp_tempo(pm_from + q));
        end
    endtask

    task automatic predict_position(cmd_item_t it, output position_t r);
        bit fired;
        fired      = 1'b0;
        pm_changed = 1'b0;
        pm_ended   = 1'b0;
        case (it.cmd)
            CMD_ADVANCE: advance_time(int'(it.d.elapsed), fired);
            CMD_START: begin
                find_section();
                fired      = 1'b1;
                pm_running = 1'b1;
                pm_accum   = 0;
            end
            CMD_STOP: pm_running = 1'b0;
            CMD_RESET_POS: begin
                pm_running = 1'b0;
                pm_measure = 1;
                pm_beat    = 1;
                pm_tick    = 0;
                pm_accum   = 0;
            end
            CMD_SET_POS: begin
                pm_measure = int'($signed(it.d.measure));
                pm_beat    = int'(it.d.beat);
                pm_tick    = int'(it.d.tick);
                if (pm_running) find_section();
            end
            CMD_LOAD: begin
                sect_bounds[it.d.index] = {it.d.last, it.d.first};
                sect_tempi[it.d.index]  = {it.d.beats, it.d.target, it.d.tempo};
            end
            default: ;
        endcase
        r.fired   = fired;
        r.measure = pm_measure[15:0];
        r.beat    = pm_beat[5:0];
        r.tick    = pm_tick[9:0];
        r.section = pm_section[3:0];
        r.changed = pm_changed;
        r.ended   = pm_ended;
        r.running = pm_running;
        r.tempo   = pm_tempo[15:0];
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            REG_TPB: begin
                cfg_tpb = val[9:0];
                load_tempo(pm_tempo);
            end
            REG_TEMPO: begin
                cfg_tempo0 = val;
                load_tempo(cfg_tempo0);
            end
            REG_BEATS: begin
                cfg_beats0 = val[5:0];
                pm_beats   = (cfg_beats0 == 0) ? 1 : int'(cfg_beats0);
            end
            default: cfg_count = val[4:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic cmd_item_t mk_cmd(logic [2:0] c);
        cmd_item_t it;
        it.cmd = c;
        it.d   = '0;
        it.d.beat = 6'd1;
        return it;
    endfunction

    function automatic cmd_item_t mk_advance(int us);
        cmd_item_t it;
        it = mk_cmd(CMD_ADVANCE);
        it.d.elapsed = us[15:0];
        return it;
    endfunction

    function automatic cmd_item_t mk_setpos(int m, int b, int t);
        cmd_item_t it;
        it = mk_cmd(CMD_SET_POS);
        it.d.measure = m[15:0];
        it.d.beat    = b[5:0];
        it.d.tick    = t[9:0];
        return it;
    endfunction

    function automatic cmd_item_t mk_load(int i, int f, int l, int t0, int t1, int bt);
        cmd_item_t it;
        it = mk_cmd(CMD_LOAD);
        it.d.index  = i[3:0];
        it.d.first  = f[14:0];
        it.d.last   = l[14:0];
        it.d.tempo  = t0[15:0];
        it.d.target = t1[15:0];
        it.d.beats  = bt[5:0];
        return it;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_pos.size() != 0)
            @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    task automatic run_phase(int tpb, int tempo, int bts, int n, int items);
        int cur, f, l, t0, r, bt;
        cur = 1;
        wait_drained();
        cfg_write(REG_TPB, tpb[15:0]);
        cfg_write(REG_TEMPO, tempo[15:0]);
        cfg_write(REG_BEATS, bts[15:0]);
        cfg_write(REG_COUNT, n[15:0]);
        for (int i = 0; i < n; i++) begin
            l  = cur + $urandom_range(0, 2);
            t0 = $urandom_range(16, 65535);
            bt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
            pending_cmds.push_back(mk_load(i, cur, l, t0,
                ($urandom_range(0, 1) == 0) ? t0 : $urandom_range(16, 65535), bt));
            cur = l + 1;
        end
        pending_cmds.push_back(mk_cmd(CMD_START));
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                pending_cmds.push_back(mk_advance(($urandom_range(0, 9) < 7) ? 65535
                                                  : $urandom_range(0, 65535)));
            else if (r < 78)
                pending_cmds.push_back(mk_cmd(CMD_START));
            else if (r < 82)
                pending_cmds.push_back(mk_cmd(CMD_STOP));
            else if (r < 86)
                pending_cmds.push_back(mk_setpos(
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4096) - 4096
                                                : $urandom_range(1, cur + 1),
                    $urandom_range(1, 32),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, tpb - 1)
                                                : $urandom_range(0, 959)));
            else if (r < 89)
                pending_cmds.push_back(mk_cmd(CMD_RESET_POS));
            else if (r < 95) begin
                f  = $urandom_range(1, cur + 1);
                l  = ($urandom_range(0, 3) == 0 && f > 1) ? f - 1 : f + $urandom_range(0, 2);
                t0 = $urandom_range(16, 65535);
                pending_cmds.push_back(mk_load($urandom_range(0, 15), f, l, t0,
                    ($urandom_range(0, 1) == 0) ? t0 : $urandom_range(16, 65535),
                    $urandom_range(1, 4)));
            end else if (r < 97)
                pending_cmds.push_back(mk_cmd(($urandom_range(0, 1) == 0) ? CMD_SPARE_6
                                                                          : CMD_SPARE_7));
            else
                pending_cmds.push_back(mk_advance($urandom_range(0, 255)));
        end
    endtask

    task automatic check_field(string name, logic [15:0] e, logic [15:0] a);
        if (e !== a) begin
            $display("%0t %s mismatch: expected %0h actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || tx_got) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur_cmd = pending_cmds.pop_front();
                s_axis_tdata  <= cur_cmd.d;
                s_axis_tuser  <= cur_cmd.cmd;
                s_axis_tvalid <= 1'b1;
                tx_gap = draw_wait();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (rx_long_req) begin
            rx_long_req = 1'b0;
            rx_long_cnt = RX_LONG_HOLD;
        end
        if (rx_got) rx_wait = draw_wait();
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_long_cnt > 0) begin
            rx_long_cnt--;
            m_axis_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // input prediction, output check, watchdog
    always @(posedge i_clk) begin
        position_t exp_r, act_r;
        tx_got <= s_axis_tvalid && s_axis_tready;
        rx_got <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_position(cur_cmd, exp_r);
            expected_pos.push_back(exp_r);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act_r = position_t'(m_axis_tdata);
            if (expected_pos.size() == 0) begin
                $display("%0t unexpected result beat: expected none actual %0h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                exp_r = expected_pos.pop_front();
                check_field("tick_fired", exp_r.fired, act_r.fired);
                check_field("measure", exp_r.measure, act_r.measure);
                check_field("beat", exp_r.beat, act_r.beat);
                check_field("tick", exp_r.tick, act_r.tick);
                check_field("section", exp_r.section, act_r.section);
                check_field("section_changed", exp_r.changed, act_r.changed);
                check_field("song_ended", exp_r.ended, act_r.ended);
                check_field("running", exp_r.running, act_r.running);
                check_field("tempo", exp_r.tempo, act_r.tempo);
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        tx_gap = 0; rx_wait = 0; rx_long_cnt = 0; idle_cycles = 0; errors = 0;
        tx_got = 0; rx_got = 0; rx_long_req = 0; no_idle = 0;
        cfg_tpb = 10'd24; cfg_tempo0 = 16'd1920; cfg_beats0 = 6'd4; cfg_count = 5'd0;
        pm_measure = 1; pm_beat = 1; pm_tick = 0; pm_section = 0;
        pm_running = 0; pm_accum = 0; pm_beats = 4; pm_ramp = 0;
        pm_x0 = 0; pm_x1 = 0; pm_from = 0; pm_to = 0;
        load_tempo(1920);
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: stopped behavior, unknown commands, extreme positions
        pending_cmds.push_back(mk_cmd(CMD_SPARE_6));
        pending_cmds.push_back(mk_cmd(CMD_SPARE_7));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_cmd(CMD_START));
        pending_cmds.push_back(mk_advance(0));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_cmd(CMD_STOP));
        pending_cmds.push_back(mk_setpos(-4096, 32, 959));
        pending_cmds.push_back(mk_cmd(CMD_START));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_setpos(32767, 4, 23));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_advance(65535));
        pending_cmds.push_back(mk_cmd(CMD_RESET_POS));
        // fill the whole table; count is still zero
        pending_cmds.push_back(mk_load(15, 32767, 32767, 65535, 16, 32));
        pending_cmds.push_back(mk_load(0, 1, 1, 16, 16, 1));
        for (int i = 1; i < 15; i++)
            pending_cmds.push_back(mk_load(i, i + 1, i + 1, 1920 + 64 * i,
                                           (i % 2) ? 1920 : 3840, 1 + (i % 4)));

        run_phase(24, 1920, 4, 16, 120);
        run_phase(1, 65535, 1, 16, 120);
        rx_long_req = 1'b1;
        run_phase(960, 16, 32, 1, 120);
        no_idle = 1'b1;
        run_phase(1, 16, 1, 2, 60);
        run_phase(2, 4000, 2, 5, 100);
        no_idle = 1'b0;
        for (int p = 0; p < 10; p++)
            run_phase(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                  : $urandom_range(1, 960),
                      $urandom_range(16, 65535), $urandom_range(1, 4),
                      ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16), 120);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
